>>> design/keyword_substitution_cipher_macros.svh
// assertion macros shared by the keyword substitution cipher modules
`ifndef KEYWORD_SUBSTITUTION_CIPHER_MACROS_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every edge out of reset
`define KSC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("keyword cipher check failed");
// condition that must hold in the cycle after the trigger
`define KSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyword cipher check failed");
`else
`define KSC_ASSERT(lbl, prop)
`define KSC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/ksc_pkg.sv
// shared types, command codes and character helpers of the keyword cipher
`default_nettype none
package ksc_pkg;

	// width of a letter code and of a table entry
	localparam int LW = 5;

	// command codes
	localparam logic [2:0] CMD_CLEAR = 3'd0;
	localparam logic [2:0] CMD_KEY   = 3'd1;
	localparam logic [2:0] CMD_FIN   = 3'd2;
	localparam logic [2:0] CMD_ENC   = 3'd3;
	localparam logic [2:0] CMD_DEC   = 3'd4;

	// character codes
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;

	// control from the front end to the table block
	typedef struct packed {
		logic rd;
		logic key_wr;
		logic fin;
	} ksc_req_t;

	// true for an ascii letter of either case
	function automatic logic is_letter(input logic [7:0] ch);
		is_letter = (ch inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]});
	endfunction

	// letter code 0..25 with lower case folded to upper
	function automatic logic [LW-1:0] letter_idx(input logic [7:0] ch);
		logic [7:0] d;
		if (ch inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
			d = ch - CH_LOWER_A;
		end else begin
			d = ch - CH_UPPER_A;
		end
		letter_idx = d[LW-1:0];
	endfunction

endpackage
`default_nettype wire

>>> design/ksc_tables.sv
// forward and inverse substitution tables with the finalize sequencer
`default_nettype none
`include "keyword_substitution_cipher_macros.svh"
module ksc_tables #(
	parameter int ALPHABET_SIZE = 26
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  ksc_pkg::ksc_req_t                   req,
	input  wire  [ksc_pkg::LW-1:0]              idx,
	input  wire  [$clog2(ALPHABET_SIZE+1)-1:0]  key_len,
	input  wire  [ALPHABET_SIZE-1:0]            used,
	output logic                                busy,
	output logic [ksc_pkg::LW-1:0]              fwd_val,
	output logic [ksc_pkg::LW-1:0]              inv_val
);
	import ksc_pkg::*;

	localparam int AW = $clog2(ALPHABET_SIZE);
	localparam int KW = $clog2(ALPHABET_SIZE + 1);
	localparam logic [LW:0] NUM = (LW+1)'(ALPHABET_SIZE);
	localparam logic [KW-1:0] LAST_SLOT = KW'(ALPHABET_SIZE - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FILL  = 2'd1;
	localparam logic [1:0] ST_INV   = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [LW-1:0] fwd_mem [ALPHABET_SIZE];
	logic [LW-1:0] inv_mem [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] fwd_vld_q;
	logic [ALPHABET_SIZE-1:0] inv_vld_q;

	logic [1:0]               state_q;
	logic [KW-1:0]            slot_q;
	logic [ALPHABET_SIZE-1:0] avail_q;

	logic [LW-1:0] fwd_rd_s1;
	logic [LW-1:0] inv_rd_s1;
	logic          fwd_hit_s1;
	logic          inv_hit_s1;
	logic [LW-1:0] rd_idx_s1;

	logic          sw_go_s1;
	logic [LW-1:0] sw_rd_s1;
	logic          sw_hit_s1;
	logic [AW-1:0] sw_slot_s1;
	logic [LW-1:0] sw_val;

	logic [LW-1:0] pick;
	logic          found;
	logic          fwd_we;
	logic [AW-1:0] fwd_waddr;
	logic [LW-1:0] fwd_wdata;
	logic [AW-1:0] fwd_raddr;

	assign busy = (state_q != ST_IDLE);

	// lowest letter not yet taken by the key or an earlier fill slot
	always_comb begin
		pick = '0;
		found = 1'b0;
		for (int i = 0; i < ALPHABET_SIZE; i++) begin
			if (avail_q[i] && !found) begin
				pick = LW'(i);
				found = 1'b1;
			end
		end
	end

	// forward write port: key letters or the fill sweep
	always_comb begin
		fwd_we = req.key_wr || (state_q == ST_FILL);
		if (state_q == ST_FILL) begin
			fwd_waddr = slot_q[AW-1:0];
			fwd_wdata = pick;
		end else begin
			fwd_waddr = key_len[AW-1:0];
			fwd_wdata = idx;
		end
	end

	// forward read address: text lookup or the inverse sweep
	assign fwd_raddr = busy ? slot_q[AW-1:0] : idx[AW-1:0];

	// entry of the inverse sweep, identity when never written
	assign sw_val = sw_hit_s1 ? sw_rd_s1 : LW'(sw_slot_s1);

	// table memories
	always_ff @(posedge clk) begin
		if (fwd_we) begin
			fwd_mem[fwd_waddr] <= fwd_wdata;
		end
		if (req.rd) begin
			fwd_rd_s1 <= fwd_mem[fwd_raddr];
			inv_rd_s1 <= inv_mem[idx[AW-1:0]];
			fwd_hit_s1 <= fwd_vld_q[idx[AW-1:0]];
			inv_hit_s1 <= inv_vld_q[idx[AW-1:0]];
			rd_idx_s1 <= idx;
		end
		if (state_q == ST_INV) begin
			sw_rd_s1 <= fwd_mem[fwd_raddr];
			sw_hit_s1 <= fwd_vld_q[fwd_raddr];
			sw_slot_s1 <= slot_q[AW-1:0];
		end
		if (sw_go_s1) begin
			inv_mem[sw_val[AW-1:0]] <= LW'(sw_slot_s1);
		end
	end

	// text lookups read as identity until the entry is written
	assign fwd_val = fwd_hit_s1 ? fwd_rd_s1 : rd_idx_s1;
	assign inv_val = inv_hit_s1 ? inv_rd_s1 : rd_idx_s1;

	// written flags and the finalize sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= '0;
			inv_vld_q <= '0;
			state_q <= ST_IDLE;
			slot_q <= '0;
			avail_q <= '0;
			sw_go_s1 <= 1'b0;
		end else begin
			sw_go_s1 <= (state_q == ST_INV);
			if (fwd_we) begin
				fwd_vld_q[fwd_waddr] <= 1'b1;
			end
			if (sw_go_s1) begin
				inv_vld_q[sw_val[AW-1:0]] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.fin) begin
						avail_q <= ~used;
						if ({1'b0, key_len} >= (KW+1)'(ALPHABET_SIZE)) begin
							slot_q <= '0;
							state_q <= ST_INV;
						end else begin
							slot_q <= key_len;
							state_q <= ST_FILL;
						end
					end
				end
				ST_FILL: begin
					avail_q <= avail_q & ~({{(ALPHABET_SIZE-1){1'b0}}, 1'b1} << pick);
					if (slot_q == LAST_SLOT) begin
						slot_q <= '0;
						state_q <= ST_INV;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				ST_INV: begin
					if (slot_q == LAST_SLOT) begin
						state_q <= ST_DRAIN;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`KSC_ASSERT(a_fin_when_idle, !(req.fin && busy))
	`KSC_ASSERT(a_fill_has_letter, !(state_q == ST_FILL && avail_q == '0))
	`KSC_ASSERT(a_inv_addr_range, !(sw_go_s1 && ({1'b0, sw_val} >= NUM)))
	`KSC_ASSERT_NEXT(a_drain_ends, state_q == ST_DRAIN, state_q == ST_IDLE && !sw_go_s1)

endmodule
`default_nettype wire

>>> design/keyword_substitution_cipher.sv
// keyword substitution cipher: key loading, handshakes and result register
//
//  channel  signals                       direction  beat
//  req      req_valid req_ready cmd       in         one command and byte
//           char_in
//  rsp      rsp_valid rsp_ready char_out  out        one translated byte
//
// encrypt, decrypt, key byte and clear are taken one beat a cycle while req_ready is high.
// text lookups read the table memories at accept into the s1 stage and reach
// the output register when s1 moves on; the memory read port is registered.
// finalize holds req_ready low through the fill sweep over the free slots,
// the inverse sweep over every slot and the drain state of the inverse write port.
// after reset both tables read as identity through per-entry written flags.
// with rsp_ready low, two results are held before req_ready drops.
`default_nettype none
`include "keyword_substitution_cipher_macros.svh"
module keyword_substitution_cipher #(
	parameter int ALPHABET_SIZE = 26
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        req_valid,
	output logic       req_ready,
	input  wire  [2:0] cmd,
	input  wire  [7:0] char_in,
	output logic       rsp_valid,
	input  wire        rsp_ready,
	output logic [7:0] char_out
);
	import ksc_pkg::*;

	localparam int AW = $clog2(ALPHABET_SIZE);
	localparam int KW = $clog2(ALPHABET_SIZE + 1);
	localparam logic [LW:0] NUM = (LW+1)'(ALPHABET_SIZE);
	localparam logic [KW:0] NUM_K = (KW+1)'(ALPHABET_SIZE);

	logic [ALPHABET_SIZE-1:0] used_q;
	logic [KW-1:0]            key_len_q;

	logic       s1_vld_q;
	logic       s1_pass_q;
	logic       s1_dec_q;
	logic [7:0] s1_char_q;
	logic       rsp_vld_q;
	logic [7:0] char_out_q;

	logic          acc;
	logic          s1_move;
	logic          busy;
	logic          is_clr;
	logic          is_key;
	logic          is_fin;
	logic          is_text;
	logic          is_pass;
	logic          letter_ok;
	logic [LW-1:0] idx;
	logic          key_wr;
	logic          has_res;
	ksc_req_t      treq;
	logic [LW-1:0] fwd_val;
	logic [LW-1:0] inv_val;
	logic [LW-1:0] map_val;

	// command decode
	always_comb begin
		is_clr = 1'b0;
		is_key = 1'b0;
		is_fin = 1'b0;
		is_text = 1'b0;
		case (cmd)
			CMD_CLEAR: is_clr = 1'b1;
			CMD_KEY:   is_key = 1'b1;
			CMD_FIN:   is_fin = 1'b1;
			CMD_ENC:   is_text = 1'b1;
			CMD_DEC:   is_text = 1'b1;
			default: begin
			end
		endcase
	end

	// byte classification
	assign idx = letter_idx(char_in);
	assign letter_ok = is_letter(char_in) && ({1'b0, idx} < NUM);
	assign is_pass = (char_in inside {CH_SPACE, CH_NUL});
	assign has_res = is_text && (is_pass || letter_ok);

	// handshake: one result in s1, one in the output register
	assign s1_move = s1_vld_q && (!rsp_vld_q || rsp_ready);
	assign req_ready = !busy && (!s1_vld_q || s1_move);
	assign acc = req_valid && req_ready;

	assign key_wr = acc && is_key && letter_ok && ({1'b0, key_len_q} < NUM_K)
		&& !used_q[idx[AW-1:0]];

	assign treq.rd = acc && is_text;
	assign treq.key_wr = key_wr;
	assign treq.fin = acc && is_fin;

	ksc_tables #(
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) u_tables (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (treq),
		.idx    (idx),
		.key_len(key_len_q),
		.used   (used_q),
		.busy   (busy),
		.fwd_val(fwd_val),
		.inv_val(inv_val)
	);

	// key state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			key_len_q <= '0;
		end else if (acc && is_clr) begin
			used_q <= '0;
			key_len_q <= '0;
		end else if (key_wr) begin
			used_q[idx[AW-1:0]] <= 1'b1;
			key_len_q <= key_len_q + 1'b1;
		end
	end

	// result stage and output register
	assign map_val = s1_dec_q ? inv_val : fwd_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (acc && has_res) begin
				s1_vld_q <= 1'b1;
			end else if (s1_move) begin
				s1_vld_q <= 1'b0;
			end
			if (s1_move) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && has_res) begin
			s1_pass_q <= is_pass;
			s1_dec_q <= (cmd == CMD_DEC);
			s1_char_q <= char_in;
		end
		if (s1_move) begin
			char_out_q <= s1_pass_q ? s1_char_q : (CH_UPPER_A + {3'b000, map_val});
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign char_out = char_out_q;

	`KSC_ASSERT(a_key_count, $countones(used_q) == key_len_q)
	`KSC_ASSERT_NEXT(a_key_grows, key_wr, key_len_q == KW'($past(key_len_q) + 1'b1))
	`KSC_ASSERT_NEXT(a_s1_held, s1_vld_q && !s1_move, s1_vld_q && $stable(s1_char_q))

endmodule
`default_nettype wire

>>> test/keyword_substitution_cipher_test.sv
// self-checking testbench for the keyword substitution cipher, with its own cipher predictor
`default_nettype none
module keyword_substitution_cipher_test;
	import ksc_pkg::*;

	localparam int ALPHA        = 26;
	localparam int ITEM_TARGET  = 1500;
	localparam int QUIET_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;

	// command codes the block ignores
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	// how a directed row is checked
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_CHAR
	} row_check_t;

	typedef struct {
		logic [2:0] op;
		logic [7:0] ch;
		row_check_t chk;
		logic [7:0] want;
	} stim_row_t;

	localparam int DIR_ROWS = 25;

	// directed rows: reset identity, pass-through bytes, dropped bytes and commands, a short key, finalize, clear
	stim_row_t dir_rows [DIR_ROWS] = '{
		'{CMD_ENC, "A", CHK_CHAR, "A"},
		'{CMD_DEC, "z", CHK_CHAR, "Z"},
		'{CMD_ENC, CH_NUL, CHK_CHAR, CH_NUL},
		'{CMD_DEC, CH_SPACE, CHK_CHAR, CH_SPACE},
		'{CMD_ENC, 8'hFF, CHK_NONE, CH_NUL},
		'{CMD_DEC, "@", CHK_NONE, CH_NUL},
		'{CMD_ENC, "{", CHK_NONE, CH_NUL},
		'{CMD_SPARE_LO, "A", CHK_NONE, CH_NUL},
		'{CMD_SPARE_HI, 8'hFF, CHK_NONE, CH_NUL},
		'{CMD_KEY, "Z", CHK_NONE, CH_NUL},
		'{CMD_KEY, "e", CHK_NONE, CH_NUL},
		'{CMD_KEY, "b", CHK_NONE, CH_NUL},
		'{CMD_KEY, "R", CHK_NONE, CH_NUL},
		'{CMD_KEY, "a", CHK_NONE, CH_NUL},
		'{CMD_KEY, "z", CHK_NONE, CH_NUL},
		'{CMD_KEY, "1", CHK_NONE, CH_NUL},
		'{CMD_ENC, "a", CHK_MODEL, CH_NUL},
		'{CMD_DEC, "Z", CHK_MODEL, CH_NUL},
		'{CMD_FIN, 8'hFF, CHK_NONE, CH_NUL},
		'{CMD_ENC, "y", CHK_MODEL, CH_NUL},
		'{CMD_ENC, "F", CHK_MODEL, CH_NUL},
		'{CMD_DEC, "Z", CHK_MODEL, CH_NUL},
		'{CMD_DEC, 8'h60, CHK_NONE, CH_NUL},
		'{CMD_CLEAR, 8'h00, CHK_NONE, CH_NUL},
		'{CMD_ENC, "B", CHK_MODEL, CH_NUL}
	};

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	logic [2:0] cmd;
	logic [7:0] char_in;
	logic       rsp_valid;
	logic       rsp_ready;
	logic [7:0] char_out;

	keyword_substitution_cipher #(
		.ALPHABET_SIZE(ALPHA)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.cmd(cmd),
		.char_in(char_in),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.char_out(char_out)
	);

	// predictor state
	logic [4:0]  fwd_map [32];
	logic [4:0]  inv_map [32];
	logic [31:0] used_mask;
	int          key_len;

	logic [7:0] expected_chars [$];
	int         mismatches = 0;
	int         beats_out = 0;
	int         quiet_cycles = 0;
	int         items_sent = 0;
	bit         steady = 0;
	bit         valid_held = 0;
	logic [7:0] want_char;

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// letter code of an ascii byte, -1 for anything else
	function automatic int letter_code(input logic [7:0] ch);
		if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			return int'(ch) - int'(CH_UPPER_A);
		end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
			return int'(ch) - int'(CH_LOWER_A);
		end
		return -1;
	endfunction

	// fill the free slots with unused letters in order, then invert
	task automatic rebuild_maps();
		int nxt;
		nxt = 0;
		for (int slot = key_len; slot < ALPHA; slot++) begin
			while (nxt < ALPHA && used_mask[nxt]) nxt++;
			fwd_map[slot] = nxt[4:0];
			nxt++;
		end
		for (int slot = 0; slot < ALPHA; slot++) begin
			inv_map[fwd_map[slot]] = slot[4:0];
		end
	endtask

	// cipher step for one accepted beat
	task automatic predict_cipher(input logic [2:0] op, input logic [7:0] ch,
			output bit emits, output logic [7:0] res);
		int idx;
		logic [4:0] v;
		idx = letter_code(ch);
		emits = 1'b0;
		res = CH_NUL;
		case (op)
			CMD_CLEAR: begin
				used_mask = '0;
				key_len = 0;
			end
			CMD_KEY: begin
				if (idx >= 0 && idx < ALPHA && key_len < ALPHA && !used_mask[idx]) begin
					fwd_map[key_len] = idx[4:0];
					used_mask[idx] = 1'b1;
					key_len++;
				end
			end
			CMD_FIN: begin
				rebuild_maps();
			end
			CMD_ENC, CMD_DEC: begin
				if (ch == CH_SPACE || ch == CH_NUL) begin
					emits = 1'b1;
					res = ch;
				end else if (idx >= 0 && idx < ALPHA) begin
					v = (op == CMD_ENC) ? fwd_map[idx] : inv_map[idx];
					emits = 1'b1;
					res = CH_UPPER_A + {3'b000, v};
				end
			end
			default: begin
			end
		endcase
	endtask

	// queue one expected result beat
	task automatic note_result(input logic [7:0] c);
		expected_chars = {expected_chars, c};
	endtask

	// drop valid if it was left high after the last beat, and wait on the clock so the block sees the drop
	task automatic lower_valid();
		if (valid_held) begin
			req_valid <= 1'b0;
			valid_held = 0;
			@(posedge clk);
		end
	endtask

	// offer one beat, predict on acceptance, then idle for a random gap (none in steady mode)
	task automatic issue(input logic [2:0] op, input logic [7:0] ch, input row_check_t chk,
			input logic [7:0] want);
		bit emits;
		logic [7:0] res;
		int gap;
		req_valid <= 1'b1;
		cmd <= op;
		char_in <= ch;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		predict_cipher(op, ch, emits, res);
		if (chk == CHK_CHAR) begin
			note_result(want);
		end else if (chk == CHK_MODEL && emits) begin
			note_result(res);
		end
		if (op <= CMD_DEC) items_sent++;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			valid_held = 0;
			repeat (gap) @(posedge clk);
		end else begin
			valid_held = 1;
		end
	endtask

	// hold the sender until every expected result is back
	task automatic drain_results();
		lower_valid();
		while (expected_chars.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_letter();
		logic [7:0] base;
		base = $urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A;
		return base + 8'($urandom_range(0, ALPHA - 1));
	endfunction

	function automatic logic [7:0] text_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return rand_letter();
		if (r < 80) return CH_SPACE;
		if (r < 85) return CH_NUL;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] key_byte();
		if ($urandom_range(0, 99) < 85) return rand_letter();
		return 8'($urandom_range(0, 255));
	endfunction

	// stimulus
	initial begin
		int seq;
		int r;
		int perm [ALPHA];
		int j;
		int t;
		logic [2:0] op;
		arst_n = 1'b0;
		req_valid = 1'b0;
		cmd = CMD_CLEAR;
		char_in = 8'h00;
		for (int i = 0; i < 32; i++) begin
			fwd_map[i] = i[4:0];
			inv_map[i] = i[4:0];
		end
		used_mask = '0;
		key_len = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			issue(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].chk, dir_rows[i].want);
		end

		// random sequences: mostly clear, key, finalize, text
		seq = 0;
		while (items_sent < ITEM_TARGET) begin
			steady = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 10) begin
				repeat ($urandom_range(5, 20)) begin
					issue(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), CHK_MODEL, CH_NUL);
				end
			end else begin
				if (r >= 15) issue(CMD_CLEAR, 8'($urandom_range(0, 255)), CHK_MODEL, CH_NUL);
				if ($urandom_range(0, 9) == 0) begin
					// whole alphabet in random order, then letters that must be skipped
					for (int i = 0; i < ALPHA; i++) perm[i] = i;
					for (int i = ALPHA - 1; i > 0; i--) begin
						j = $urandom_range(0, i);
						t = perm[i];
						perm[i] = perm[j];
						perm[j] = t;
					end
					for (int i = 0; i < ALPHA; i++) begin
						issue(CMD_KEY, ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(perm[i]),
							CHK_MODEL, CH_NUL);
					end
					repeat ($urandom_range(1, 4)) issue(CMD_KEY, rand_letter(), CHK_MODEL, CH_NUL);
				end else begin
					repeat ($urandom_range(0, 10)) issue(CMD_KEY, key_byte(), CHK_MODEL, CH_NUL);
				end
				if ($urandom_range(0, 9) != 0) begin
					issue(CMD_FIN, 8'($urandom_range(0, 255)), CHK_MODEL, CH_NUL);
				end
				repeat ($urandom_range(3, 40)) begin
					op = $urandom_range(0, 1) ? CMD_ENC : CMD_DEC;
					issue(op, text_byte(), CHK_MODEL, CH_NUL);
				end
			end
			seq++;
			if (seq == 8 || $urandom_range(0, 99) < 3) drain_results();
		end

		// wind down
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// result side ready, with one long hold-off so the block backs up
	initial begin
		bit held;
		int n;
		held = 0;
		rsp_ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			n = pick_gap();
			if (!held && beats_out >= 150) begin
				held = 1;
				n = HOLD_CYCLES;
			end
			if (n > 0) begin
				rsp_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			beats_out++;
			if (expected_chars.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected char_out, expected none, actual %h", $time, char_out);
			end else begin
				want_char = expected_chars.pop_front();
				if (char_out !== want_char) begin
					mismatches++;
					$display("%0t: char_out mismatch, expected %h, actual %h",
						$time, want_char, char_out);
				end
			end
		end
	end

	// count cycles with no beat on either side
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// watchdog
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
